[design/udd_pkg.sv]
// Shared types, constants and the Nd digit range table for the UTF-8 digit string checker.
// No dependencies; used by udd_front, udd_fifo, udd_back and the top level.
package udd_pkg;

  localparam int unsigned CNT_W      = 25;
  localparam int unsigned CP_W       = 21;
  localparam int unsigned NUM_RANGES = 71;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [CNT_W-1:0] LIMIT_RESET = 25'h100_0000;
  localparam logic [CNT_W-1:0] CNT_MAX     = '1;

  localparam logic [CP_W-1:0] MIN_LEN2  = 21'h00080;
  localparam logic [CP_W-1:0] MIN_LEN3  = 21'h00800;
  localparam logic [CP_W-1:0] MIN_LEN4  = 21'h10000;
  localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO   = 21'h0D800;
  localparam logic [CP_W-1:0] SURR_HI   = 21'h0DFFF;

  localparam logic [2:0] SEQ_LEN2 = 3'd2;
  localparam logic [2:0] SEQ_LEN3 = 3'd3;
  localparam logic [2:0] SEQ_LEN4 = 3'd4;

  typedef enum logic [2:0] {
    CLS_NUL,
    CLS_DIGIT,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_cls_e;

  typedef enum logic [1:0] {
    VERDICT_NOT_DIGITS = 2'd0,
    VERDICT_DIGITS     = 2'd1,
    VERDICT_OVERSIZE   = 2'd2
  } verdict_e;

  typedef struct packed {
    byte_cls_e  cls;
    logic [5:0] bits;
  } byte_item_t;

  localparam logic [CP_W-1:0] ND_LO [NUM_RANGES] = '{
    21'h00030, 21'h00660, 21'h006F0, 21'h007C0, 21'h00966, 21'h009E6, 21'h00A66,
    21'h00AE6, 21'h00B66, 21'h00BE6, 21'h00C66, 21'h00CE6, 21'h00D66, 21'h00DE6,
    21'h00E50, 21'h00ED0, 21'h00F20, 21'h01040, 21'h01090, 21'h017E0, 21'h01810,
    21'h01946, 21'h019D0, 21'h01A80, 21'h01A90, 21'h01B50, 21'h01BB0, 21'h01C40,
    21'h01C50, 21'h0A620, 21'h0A8D0, 21'h0A900, 21'h0A9D0, 21'h0A9F0, 21'h0AA50,
    21'h0ABF0, 21'h0FF10, 21'h104A0, 21'h10D30, 21'h10D40, 21'h11066, 21'h110F0,
    21'h11136, 21'h111D0, 21'h112F0, 21'h11450, 21'h114D0, 21'h11650, 21'h116C0,
    21'h116D0, 21'h11730, 21'h118E0, 21'h11950, 21'h11BF0, 21'h11C50, 21'h11D50,
    21'h11DA0, 21'h11F50, 21'h16130, 21'h16A60, 21'h16AC0, 21'h16B50, 21'h16D70,
    21'h1CCF0, 21'h1D7CE, 21'h1E140, 21'h1E2F0, 21'h1E4F0, 21'h1E5F1, 21'h1E950,
    21'h1FBF0
  };

  localparam logic [CP_W-1:0] ND_HI [NUM_RANGES] = '{
    21'h00039, 21'h00669, 21'h006F9, 21'h007C9, 21'h0096F, 21'h009EF, 21'h00A6F,
    21'h00AEF, 21'h00B6F, 21'h00BEF, 21'h00C6F, 21'h00CEF, 21'h00D6F, 21'h00DEF,
    21'h00E59, 21'h00ED9, 21'h00F29, 21'h01049, 21'h01099, 21'h017E9, 21'h01819,
    21'h0194F, 21'h019D9, 21'h01A89, 21'h01A99, 21'h01B59, 21'h01BB9, 21'h01C49,
    21'h01C59, 21'h0A629, 21'h0A8D9, 21'h0A909, 21'h0A9D9, 21'h0A9F9, 21'h0AA59,
    21'h0ABF9, 21'h0FF19, 21'h104A9, 21'h10D39, 21'h10D49, 21'h1106F, 21'h110F9,
    21'h1113F, 21'h111D9, 21'h112F9, 21'h11459, 21'h114D9, 21'h11659, 21'h116C9,
    21'h116E3, 21'h11739, 21'h118E9, 21'h11959, 21'h11BF9, 21'h11C59, 21'h11D59,
    21'h11DA9, 21'h11F59, 21'h16139, 21'h16A69, 21'h16AC9, 21'h16B59, 21'h16D79,
    21'h1CCF9, 21'h1D7FF, 21'h1E149, 21'h1E2F9, 21'h1E4F9, 21'h1E5FA, 21'h1E959,
    21'h1FBF9
  };

  // Parallel compare against every range, OR-reduced.
  function automatic logic is_nd(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (cp >= ND_LO[i] && cp <= ND_HI[i]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic scalar_ok(input logic [CP_W-1:0] cp, input logic [2:0] len);
    logic ok;
    ok = 1'b1;
    if (len == SEQ_LEN2 && cp < MIN_LEN2) ok = 1'b0;
    if (len == SEQ_LEN3 && cp < MIN_LEN3) ok = 1'b0;
    if (len == SEQ_LEN4 && cp < MIN_LEN4) ok = 1'b0;
    if (cp > MAX_CP) ok = 1'b0;
    if (cp >= SURR_LO && cp <= SURR_HI) ok = 1'b0;
    return ok;
  endfunction

endpackage

[design/udd_front.sv]
// Front end: takes string bytes and classifies each into a NUL/digit/ASCII/lead/continuation/bad class.
// Depends on udd_pkg; feeds udd_fifo.
module udd_front import udd_pkg::*; (
  input  logic       byte_valid_i,
  input  logic [7:0] byte_value_i,
  output logic       byte_stall_o,
  input  logic       fifo_full_i,
  output logic       push_o,
  output byte_item_t push_item_o
);

  byte_cls_e cls;

  always_comb begin
    if (byte_value_i == 8'h00) begin
      cls = CLS_NUL;
    end else if (byte_value_i >= 8'h30 && byte_value_i <= 8'h39) begin
      cls = CLS_DIGIT;
    end else if (byte_value_i < 8'h80) begin
      cls = CLS_ASCII;
    end else if (byte_value_i <= 8'hBF) begin
      cls = CLS_CONT;
    end else if (byte_value_i >= 8'hC2 && byte_value_i <= 8'hDF) begin
      cls = CLS_LEAD2;
    end else if (byte_value_i >= 8'hE0 && byte_value_i <= 8'hEF) begin
      cls = CLS_LEAD3;
    end else if (byte_value_i >= 8'hF0 && byte_value_i <= 8'hF4) begin
      cls = CLS_LEAD4;
    end else begin
      cls = CLS_BAD;
    end
  end

  assign byte_stall_o     = fifo_full_i;
  assign push_o           = byte_valid_i && !fifo_full_i;
  assign push_item_o.cls  = cls;
  assign push_item_o.bits = byte_value_i[5:0];

endmodule

[design/udd_fifo.sv]
// Short queue of classified bytes between the front end and the decoder.
// Depends on udd_pkg.
module udd_fifo import udd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  byte_item_t push_item_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output byte_item_t pop_item_o
);

  byte_item_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]       count_q, count_d;

  assign full_o     = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[design/udd_back.sv]
// Back end: strict UTF-8 decoder, length counter, Nd range check and verdict register.
// Depends on udd_pkg; pops from udd_fifo.
module udd_back import udd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] limit_i,
  input  logic             empty_i,
  input  byte_item_t       item_i,
  output logic             pop_o,
  output logic             verdict_valid_o,
  input  logic             verdict_stall_i,
  output logic [1:0]       verdict_o
);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       pend_q, pend_d;
  logic [2:0]       seq_q, seq_d;
  logic [CP_W-1:0]  cp_q, cp_d;
  logic             failed_q, failed_d;
  // Finished scalar, registered and range-checked in the cycle after it completes.
  logic             chk_q, chk_d;
  logic [CP_W-1:0]  chk_cp_q, chk_cp_d;
  logic [2:0]       chk_len_q, chk_len_d;
  logic             out_valid_q, out_valid_d;
  verdict_e         out_q, out_d;

  logic             slot_free;
  logic             is_nul;
  logic             chk_bad;
  logic [CP_W-1:0]  cp_shift;

  assign slot_free = !out_valid_q || !verdict_stall_i;
  assign is_nul    = (item_i.cls == CLS_NUL);
  assign pop_o     = !empty_i && (!is_nul || slot_free);
  assign chk_bad   = chk_q && !(scalar_ok(chk_cp_q, chk_len_q) && is_nd(chk_cp_q));
  assign cp_shift  = {cp_q[CP_W-7:0], item_i.bits};

  assign verdict_valid_o = out_valid_q;
  assign verdict_o       = out_q;

  always_comb begin
    cnt_d       = cnt_q;
    pend_d      = pend_q;
    seq_d       = seq_q;
    cp_d        = cp_q;
    failed_d    = failed_q | chk_bad;
    chk_d       = 1'b0;
    chk_cp_d    = chk_cp_q;
    chk_len_d   = chk_len_q;
    out_valid_d = slot_free ? 1'b0 : out_valid_q;
    out_d       = out_q;

    if (pop_o) begin
      if (is_nul) begin
        out_valid_d = 1'b1;
        if (cnt_q > limit_i) begin
          out_d = VERDICT_OVERSIZE;
        end else if (cnt_q == '0 || failed_q || chk_bad || pend_q != 2'd0) begin
          out_d = VERDICT_NOT_DIGITS;
        end else begin
          out_d = VERDICT_DIGITS;
        end
        cnt_d    = '0;
        pend_d   = '0;
        seq_d    = '0;
        cp_d     = '0;
        failed_d = 1'b0;
      end else begin
        if (cnt_q <= limit_i && cnt_q != CNT_MAX) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (!failed_q) begin
          if (pend_q == 2'd0) begin
            case (item_i.cls)
              CLS_DIGIT: ;
              CLS_LEAD2: begin
                seq_d  = SEQ_LEN2;
                pend_d = 2'd1;
                cp_d   = CP_W'(item_i.bits[4:0]);
              end
              CLS_LEAD3: begin
                seq_d  = SEQ_LEN3;
                pend_d = 2'd2;
                cp_d   = CP_W'(item_i.bits[3:0]);
              end
              CLS_LEAD4: begin
                seq_d  = SEQ_LEN4;
                pend_d = 2'd3;
                cp_d   = CP_W'(item_i.bits[2:0]);
              end
              default: failed_d = 1'b1;
            endcase
          end else if (item_i.cls != CLS_CONT) begin
            failed_d = 1'b1;
            pend_d   = '0;
          end else begin
            pend_d = pend_q - 1'b1;
            if (pend_q == 2'd1) begin
              chk_d     = 1'b1;
              chk_cp_d  = cp_shift;
              chk_len_d = seq_q;
              cp_d      = '0;
              seq_d     = '0;
            end else begin
              cp_d = cp_shift;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      pend_q      <= '0;
      seq_q       <= '0;
      cp_q        <= '0;
      failed_q    <= 1'b0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      seq_q       <= seq_d;
      cp_q        <= cp_d;
      failed_q    <= failed_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_cp_q  <= chk_cp_d;
    chk_len_q <= chk_len_d;
    out_q     <= out_d;
  end

endmodule

[design/utf8_decimal_digit_string_check.sv]
// Top level of the UTF-8 decimal digit string checker.
// Depends on udd_pkg, udd_front, udd_fifo and udd_back.
//
// Bytes of a NUL-terminated string enter one per clock while byte_stall_o is low. Each is
// classified on entry and queued (four entries) for the decoder, which retires one byte
// per cycle unless a NUL waits on a held verdict: strict UTF-8 decode, a saturating
// length count against length_limit, and a check of every scalar against the Unicode Nd
// digit ranges. The terminating NUL produces one verdict (0 not all digits, 1 all
// digits, 2 oversize) in the cycle after it is taken, held in an output register; the
// NUL leaves the queue only while that register is free, so a held verdict blocks the
// decoder and, once the queue fills, the byte input. Sustained rate is one byte per
// cycle while no verdict is held. Write length_limit only while no string is in flight.
module utf8_decimal_digit_string_check import udd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             byte_valid_i,
  input  logic [7:0]       byte_value_i,
  output logic             byte_stall_o,
  output logic             verdict_valid_o,
  input  logic             verdict_stall_i,
  output logic [1:0]       verdict_o
);

  logic [CNT_W-1:0] limit_q;
  logic             fifo_full;
  logic             fifo_empty;
  logic             push;
  logic             pop;
  byte_item_t       push_item;
  byte_item_t       pop_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_wdata_i;
    end
  end

  udd_front u_front (
    .byte_valid_i (byte_valid_i),
    .byte_value_i (byte_value_i),
    .byte_stall_o (byte_stall_o),
    .fifo_full_i  (fifo_full),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  udd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .empty_o     (fifo_empty),
    .pop_item_o  (pop_item)
  );

  udd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .limit_i         (limit_q),
    .empty_i         (fifo_empty),
    .item_i          (pop_item),
    .pop_o           (pop),
    .verdict_valid_o (verdict_valid_o),
    .verdict_stall_i (verdict_stall_i),
    .verdict_o       (verdict_o)
  );

endmodule

[bench/tb_top.sv]
// Self-checking bench for the UTF-8 decimal digit string checker: byte requests in,
// one verdict per NUL out, predicted by a scoreboard class. Depends on udd_pkg and
// utf8_decimal_digit_string_check.
module tb_top import udd_pkg::*; ();

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int BYTE_GOAL    = 1700;
  localparam int NUM_PHASES   = 6;

  class digit_verdict_board;
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] count;
    int unsigned      cont_left;
    int unsigned      seq_len;
    logic [CP_W-1:0]  cp;
    bit               bad;
    verdict_e         due[$];
    int unsigned      nd_lo[NUM_RANGES];
    int unsigned      nd_hi[NUM_RANGES];
    int               errors;
    int               tally[3];

    function new();
      nd_lo = '{
        'h00030, 'h00660, 'h006F0, 'h007C0, 'h00966, 'h009E6, 'h00A66, 'h00AE6,
        'h00B66, 'h00BE6, 'h00C66, 'h00CE6, 'h00D66, 'h00DE6, 'h00E50, 'h00ED0,
        'h00F20, 'h01040, 'h01090, 'h017E0, 'h01810, 'h01946, 'h019D0, 'h01A80,
        'h01A90, 'h01B50, 'h01BB0, 'h01C40, 'h01C50, 'h0A620, 'h0A8D0, 'h0A900,
        'h0A9D0, 'h0A9F0, 'h0AA50, 'h0ABF0, 'h0FF10, 'h104A0, 'h10D30, 'h10D40,
        'h11066, 'h110F0, 'h11136, 'h111D0, 'h112F0, 'h11450, 'h114D0, 'h11650,
        'h116C0, 'h116D0, 'h11730, 'h118E0, 'h11950, 'h11BF0, 'h11C50, 'h11D50,
        'h11DA0, 'h11F50, 'h16130, 'h16A60, 'h16AC0, 'h16B50, 'h16D70, 'h1CCF0,
        'h1D7CE, 'h1E140, 'h1E2F0, 'h1E4F0, 'h1E5F1, 'h1E950, 'h1FBF0
      };
      nd_hi = '{
        'h00039, 'h00669, 'h006F9, 'h007C9, 'h0096F, 'h009EF, 'h00A6F, 'h00AEF,
        'h00B6F, 'h00BEF, 'h00C6F, 'h00CEF, 'h00D6F, 'h00DEF, 'h00E59, 'h00ED9,
        'h00F29, 'h01049, 'h01099, 'h017E9, 'h01819, 'h0194F, 'h019D9, 'h01A89,
        'h01A99, 'h01B59, 'h01BB9, 'h01C49, 'h01C59, 'h0A629, 'h0A8D9, 'h0A909,
        'h0A9D9, 'h0A9F9, 'h0AA59, 'h0ABF9, 'h0FF19, 'h104A9, 'h10D39, 'h10D49,
        'h1106F, 'h110F9, 'h1113F, 'h111D9, 'h112F9, 'h11459, 'h114D9, 'h11659,
        'h116C9, 'h116E3, 'h11739, 'h118E9, 'h11959, 'h11BF9, 'h11C59, 'h11D59,
        'h11DA9, 'h11F59, 'h16139, 'h16A69, 'h16AC9, 'h16B59, 'h16D79, 'h1CCF9,
        'h1D7FF, 'h1E149, 'h1E2F9, 'h1E4F9, 'h1E5FA, 'h1E959, 'h1FBF9
      };
      limit  = LIMIT_RESET;
      errors = 0;
      tally  = '{0, 0, 0};
      clear_string();
    endfunction

    function void clear_string();
      count     = '0;
      cont_left = 0;
      seq_len   = 0;
      cp        = '0;
      bad       = 1'b0;
    endfunction

    function void set_limit(logic [CNT_W-1:0] v);
      limit = v;
    endfunction

    function int outstanding();
      return due.size();
    endfunction

    function bit is_digit_cp(logic [CP_W-1:0] c);
      for (int i = 0; i < NUM_RANGES; i++) begin
        if (c >= nd_lo[i] && c <= nd_hi[i]) return 1'b1;
      end
      return 1'b0;
    endfunction

    // Shortest-form, surrogate and range rules for a completed scalar.
    function bit legal_scalar(logic [CP_W-1:0] c, int unsigned n);
      if (n == 2 && c < 'h80) return 1'b0;
      if (n == 3 && c < 'h800) return 1'b0;
      if (n == 4 && c < 'h10000) return 1'b0;
      if (c > 'h10FFFF) return 1'b0;
      if (c >= 'hD800 && c <= 'hDFFF) return 1'b0;
      return 1'b1;
    endfunction

    // Note an accepted byte request; a NUL queues the verdict it must produce.
    function void take_byte(logic [7:0] b);
      verdict_e v;
      if (b == 8'h00) begin
        if (count > limit) v = VERDICT_OVERSIZE;
        else if (count == 0 || bad || cont_left != 0) v = VERDICT_NOT_DIGITS;
        else v = VERDICT_DIGITS;
        due.push_back(v);
        clear_string();
        return;
      end
      if (count <= limit && count < CNT_MAX) count++;
      if (bad) return;
      if (cont_left == 0) begin
        if (b < 8'h80) begin
          if (b < 8'h30 || b > 8'h39) bad = 1'b1;
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          seq_len = 2; cont_left = 1; cp = CP_W'(b & 8'h1F);
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          seq_len = 3; cont_left = 2; cp = CP_W'(b & 8'h0F);
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          seq_len = 4; cont_left = 3; cp = CP_W'(b & 8'h07);
        end else begin
          bad = 1'b1;
        end
        return;
      end
      if (b < 8'h80 || b > 8'hBF) begin
        bad       = 1'b1;
        cont_left = 0;
        return;
      end
      cp = {cp[CP_W-7:0], b[5:0]};
      cont_left--;
      if (cont_left == 0) begin
        if (!legal_scalar(cp, seq_len) || !is_digit_cp(cp)) bad = 1'b1;
        cp      = '0;
        seq_len = 0;
      end
    endfunction

    function void check_verdict(logic [1:0] got);
      verdict_e want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: verdict mismatch, expected none, got %0d", $time, got);
        return;
      end
      want = due.pop_front();
      tally[want]++;
      if (got !== want) begin
        errors++;
        $display("%0t: verdict mismatch, expected %0d, got %0d", $time, want, got);
      end
    endfunction

    function int unsigned pick_digit(bit ascii_ok);
      int unsigned idx;
      int unsigned r;
      idx = $urandom_range(NUM_RANGES - 1, ascii_ok ? 0 : 1);
      r   = $urandom_range(0, 9);
      if (ascii_ok && r < 3) return $urandom_range('h39, 'h30);
      if (r == 3) return nd_lo[idx];
      if (r == 4) return nd_hi[idx];
      return $urandom_range(nd_hi[idx], nd_lo[idx]);
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni          = 1'b0;
  logic             cfg_we_i        = 1'b0;
  logic [CNT_W-1:0] cfg_wdata_i     = '0;
  logic             byte_valid_i    = 1'b0;
  logic [7:0]       byte_value_i    = '0;
  logic             byte_stall_o;
  logic             verdict_valid_o;
  logic             verdict_stall_i = 1'b0;
  logic [1:0]       verdict_o;

  digit_verdict_board board;
  logic [7:0]         str_bytes[$];
  logic [CNT_W-1:0]   limits[NUM_PHASES];
  int                 bytes_sent   = 0;
  int                 cycles       = 0;
  int                 stall_hold   = 0;
  int                 limits_tried = 1;
  bit                 calm         = 1'b0;

  utf8_decimal_digit_string_check dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .byte_valid_i    (byte_valid_i),
    .byte_value_i    (byte_value_i),
    .byte_stall_o    (byte_stall_o),
    .verdict_valid_o (verdict_valid_o),
    .verdict_stall_i (verdict_stall_i),
    .verdict_o       (verdict_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver back-pressure: hold a random level for a random run of cycles.
  always @(posedge clk_i) begin
    if (!rst_ni || calm) begin
      verdict_stall_i <= 1'b0;
      stall_hold      <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      verdict_stall_i <= ($urandom_range(0, 99) < 35);
      stall_hold      <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 8)
                                                      : $urandom_range(3, 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && verdict_valid_o && !verdict_stall_i) board.check_verdict(verdict_o);
  end

  function automatic int unsigned min_len(int unsigned cp);
    if (cp < 'h80) return 1;
    if (cp < 'h800) return 2;
    if (cp < 'h10000) return 3;
    return 4;
  endfunction

  // Encode cp in exactly n bytes; n longer than needed gives an overlong form.
  function automatic void put_scalar(int unsigned cp, int unsigned n);
    logic [20:0] c;
    c = 21'(cp);
    case (n)
      1: str_bytes.push_back({1'b0, c[6:0]});
      2: begin
        str_bytes.push_back({3'b110, c[10:6]});
        str_bytes.push_back({2'b10, c[5:0]});
      end
      3: begin
        str_bytes.push_back({4'b1110, c[15:12]});
        str_bytes.push_back({2'b10, c[11:6]});
        str_bytes.push_back({2'b10, c[5:0]});
      end
      default: begin
        str_bytes.push_back({5'b11110, c[20:18]});
        str_bytes.push_back({2'b10, c[17:12]});
        str_bytes.push_back({2'b10, c[11:6]});
        str_bytes.push_back({2'b10, c[5:0]});
      end
    endcase
  endfunction

  task automatic send_string();
    int gap;
    int r;
    foreach (str_bytes[i]) begin
      byte_value_i <= str_bytes[i];
      byte_valid_i <= 1'b1;
      do @(posedge clk_i); while (byte_stall_o);
      board.take_byte(str_bytes[i]);
      bytes_sent++;
      r = $urandom_range(0, 99);
      if (calm || r < 55) gap = 0;
      else if (r < 92) gap = $urandom_range(3, 1);
      else gap = $urandom_range(30, 8);
      if (gap != 0) begin
        byte_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Let every pending verdict come back, then give the decoder time to go idle.
  task automatic drain();
    byte_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [CNT_W-1:0] v);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_limit(v);
    limits_tried++;
  endtask

  // Mostly well-formed digit strings; the rest are empty, carry one flaw or are plain noise.
  task automatic run_random(int stop_at);
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    int unsigned cp;
    int unsigned len;
    int unsigned idx;
    while (bytes_sent < stop_at) begin
      str_bytes.delete();
      kind = $urandom_range(0, 99);
      n    = (kind >= 83 && kind < 90) ? 0 : $urandom_range(6, 1);
      pos  = $urandom_range(5, 0);
      if (kind >= 90) begin
        repeat ($urandom_range(8, 1)) str_bytes.push_back(8'($urandom_range(255, 1)));
        n = 0;
      end
      for (int i = 0; i < n; i++) begin
        if (i == pos && kind >= 55 && kind < 65) begin
          // scalar that is usually not a digit, often just outside a digit range
          case ($urandom_range(0, 2))
            0: begin
              idx = $urandom_range(NUM_RANGES - 1, 0);
              cp  = $urandom_range(0, 1) ? board.nd_lo[idx] - 1 : board.nd_hi[idx] + 1;
            end
            1: cp = $urandom_range('h7F, 1);
            default: begin
              cp = $urandom_range('h10FFFF, 'h80);
              if (cp >= 'hD800 && cp <= 'hDFFF) cp -= 'h800;
            end
          endcase
          put_scalar(cp, min_len(cp));
        end else if (i == pos && kind >= 65 && kind < 75) begin
          case ($urandom_range(0, 5))
            0: begin
              len = $urandom_range(4, 2);
              cp  = $urandom_range(len == 2 ? 'h7F : len == 3 ? 'h7FF : 'hFFFF, 0);
              put_scalar(cp, len);
            end
            1: put_scalar($urandom_range('hDFFF, 'hD800), 3);
            2: put_scalar($urandom_range('h13FFFF, 'h110000), 4);
            3: begin
              str_bytes.push_back(8'($urandom_range('hF4, 'hC2)));
              str_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range('h7F, 1)
                                                          : $urandom_range('hFF, 'hC0)));
            end
            4: str_bytes.push_back(8'($urandom_range('hBF, 'h80)));
            default: str_bytes.push_back(8'($urandom_range(0, 1) ? $urandom_range('hC1, 'hC0)
                                                                 : $urandom_range('hFF, 'hF5)));
          endcase
        end else begin
          cp = board.pick_digit(1'b1);
          put_scalar(cp, min_len(cp));
        end
      end
      if (kind >= 75 && kind < 83) begin
        // multi-byte digit cut short by the NUL
        cp  = board.pick_digit(1'b0);
        len = min_len(cp);
        put_scalar(cp, len);
        repeat ($urandom_range(len - 1, 1)) void'(str_bytes.pop_back());
      end
      str_bytes.push_back(8'h00);
      send_string();
    end
  endtask

  initial begin
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty, ASCII digits, bad byte, ASCII non-digit, Arabic-Indic nine,
    // truncated sequence, surrogate, above U+10FFFF
    str_bytes = '{8'h00,
                  8'h30, 8'h39, 8'h00,
                  8'hFF, 8'h00,
                  8'h35, 8'h2F, 8'h00,
                  8'hD9, 8'hA9, 8'h00,
                  8'hE0, 8'hA5, 8'h00,
                  8'hED, 8'hA0, 8'h80, 8'h00,
                  8'hF4, 8'h90, 8'h80, 8'h80, 8'h00};
    send_string();
    run_random(BYTE_GOAL / (NUM_PHASES + 1));

    limits[0] = CNT_W'(1);
    limits[1] = '0;
    limits[2] = CNT_W'($urandom_range(12, 2));
    limits[3] = CNT_MAX;
    limits[4] = LIMIT_RESET;
    limits[5] = CNT_W'($urandom_range(40, 1));
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_limit(limits[p]);
      calm <= (p == 2);
      run_random(BYTE_GOAL * (p + 2) / (NUM_PHASES + 1));
    end
    drain();

    $display("Sent %0d bytes under %0d length limits, including zero and all ones",
             bytes_sent, limits_tried);
    $display("Verdicts checked: %0d all digits, %0d not digits, %0d oversize",
             board.tally[VERDICT_DIGITS], board.tally[VERDICT_NOT_DIGITS],
             board.tally[VERDICT_OVERSIZE]);
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
